// ===== design/mlfp_pkg.sv =====
`default_nettype none

package mlfp_pkg;

    // header layout
    localparam int unsigned HeaderLen = 10;

    // magic bytes, first to last
    localparam logic [7:0] Magic0 = 8'h4E;
    localparam logic [7:0] Magic1 = 8'h4B;
    localparam logic [7:0] Magic2 = 8'h54;
    localparam logic [7:0] Magic3 = 8'h4D;

    // default for the payload size limit
    localparam logic [31:0] MaxPayloadReset = 32'd65536;

    // parser phase: magic bytes, type bytes, size bytes, payload
    typedef enum logic [3:0] {
        PH_MAGIC0  = 4'd0,
        PH_MAGIC1  = 4'd1,
        PH_MAGIC2  = 4'd2,
        PH_MAGIC3  = 4'd3,
        PH_TYPE0   = 4'd4,
        PH_TYPE1   = 4'd5,
        PH_SIZE0   = 4'd6,
        PH_SIZE1   = 4'd7,
        PH_SIZE2   = 4'd8,
        PH_SIZE3   = 4'd9,
        PH_PAYLOAD = 4'd10
    } phase_t;

    // per-byte status code
    typedef enum logic [1:0] {
        ST_INVALID    = 2'd0,
        ST_VALID      = 2'd1,
        ST_END_HEADER = 2'd2,
        ST_END_PACKET = 2'd3
    } status_t;

    // one result transfer
    typedef struct packed {
        status_t     status;
        logic [15:0] packet_type;
        logic [31:0] payload_size;
    } result_t;

endpackage

`default_nettype wire

// ===== design/mlfp_core.sv =====
`default_nettype none

module mlfp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire logic [7:0]       data_byte,
    input  wire logic [31:0]      max_payload_size,
    output mlfp_pkg::result_t     result
);

    mlfp_pkg::phase_t phase_reg;
    mlfp_pkg::phase_t phase_next;
    logic [15:0]      type_reg;
    logic [15:0]      type_next;
    logic [31:0]      size_reg;
    logic [31:0]      size_next;
    logic [31:0]      remaining_reg;
    logic [31:0]      remaining_next;
    mlfp_pkg::status_t status;
    logic [31:0]      size_full;
    logic             size_too_big;
    logic             size_zero;
    logic             last_payload;

    // size as it stands once the last size byte is in
    assign size_full    = {data_byte, size_reg[23:0]};
    assign size_too_big = size_full > max_payload_size;
    assign size_zero    = size_full == 32'd0;
    assign last_payload = remaining_reg <= 32'd1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                mlfp_pkg::PH_MAGIC0: begin
                    phase_next = (data_byte == mlfp_pkg::Magic0) ?
                                 mlfp_pkg::PH_MAGIC1 : mlfp_pkg::PH_MAGIC0;
                end
                mlfp_pkg::PH_MAGIC1: begin
                    phase_next = (data_byte == mlfp_pkg::Magic1) ?
                                 mlfp_pkg::PH_MAGIC2 : mlfp_pkg::PH_MAGIC0;
                end
                mlfp_pkg::PH_MAGIC2: begin
                    phase_next = (data_byte == mlfp_pkg::Magic2) ?
                                 mlfp_pkg::PH_MAGIC3 : mlfp_pkg::PH_MAGIC0;
                end
                mlfp_pkg::PH_MAGIC3: begin
                    phase_next = (data_byte == mlfp_pkg::Magic3) ?
                                 mlfp_pkg::PH_TYPE0 : mlfp_pkg::PH_MAGIC0;
                end
                mlfp_pkg::PH_TYPE0: phase_next = mlfp_pkg::PH_TYPE1;
                mlfp_pkg::PH_TYPE1: phase_next = mlfp_pkg::PH_SIZE0;
                mlfp_pkg::PH_SIZE0: phase_next = mlfp_pkg::PH_SIZE1;
                mlfp_pkg::PH_SIZE1: phase_next = mlfp_pkg::PH_SIZE2;
                mlfp_pkg::PH_SIZE2: phase_next = mlfp_pkg::PH_SIZE3;
                mlfp_pkg::PH_SIZE3: begin
                    phase_next = (size_too_big || size_zero) ?
                                 mlfp_pkg::PH_MAGIC0 : mlfp_pkg::PH_PAYLOAD;
                end
                mlfp_pkg::PH_PAYLOAD: begin
                    phase_next = last_payload ? mlfp_pkg::PH_MAGIC0 : mlfp_pkg::PH_PAYLOAD;
                end
                default: phase_next = mlfp_pkg::PH_MAGIC0;
            endcase
        end
    end

    // status and header field updates
    always_comb begin
        status         = mlfp_pkg::ST_INVALID;
        type_next      = type_reg;
        size_next      = size_reg;
        remaining_next = remaining_reg;
        unique case (phase_reg)
            mlfp_pkg::PH_MAGIC0: begin
                if (data_byte == mlfp_pkg::Magic0) status = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_MAGIC1: begin
                if (data_byte == mlfp_pkg::Magic1) status = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_MAGIC2: begin
                if (data_byte == mlfp_pkg::Magic2) status = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_MAGIC3: begin
                if (data_byte == mlfp_pkg::Magic3) status = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_TYPE0: begin
                type_next = {type_reg[15:8], data_byte};
                status    = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_TYPE1: begin
                type_next = {data_byte, type_reg[7:0]};
                status    = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_SIZE0: begin
                size_next = {size_reg[31:8], data_byte};
                status    = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_SIZE1: begin
                size_next = {size_reg[31:16], data_byte, size_reg[7:0]};
                status    = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_SIZE2: begin
                size_next = {size_reg[31:24], data_byte, size_reg[15:0]};
                status    = mlfp_pkg::ST_VALID;
            end
            mlfp_pkg::PH_SIZE3: begin
                size_next      = size_full;
                remaining_next = size_full;
                if (size_too_big) begin
                    status = mlfp_pkg::ST_INVALID;
                end else if (size_zero) begin
                    status = mlfp_pkg::ST_END_PACKET;
                end else begin
                    status = mlfp_pkg::ST_END_HEADER;
                end
            end
            mlfp_pkg::PH_PAYLOAD: begin
                remaining_next = remaining_reg - 32'd1;
                status = last_payload ? mlfp_pkg::ST_END_PACKET : mlfp_pkg::ST_VALID;
            end
            default: status = mlfp_pkg::ST_INVALID;
        endcase
    end

    // result of the byte on the input, fields after the update
    assign result.status       = status;
    assign result.packet_type  = type_next;
    assign result.payload_size = size_next;

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mlfp_pkg::PH_MAGIC0;
            type_reg  <= 16'd0;
            size_reg  <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            if (accept) begin
                type_reg <= type_next;
                size_reg <= size_next;
            end
        end
    end

    // payload byte countdown
    always_ff @(posedge aclk) begin
        if (accept) begin
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mlfp_out_stage.sv =====
`default_nettype none

module mlfp_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire mlfp_pkg::result_t result,
    output logic                   space,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [15:0]            m_packet_type,
    output logic [31:0]            m_payload_size
);

    logic              valid_reg;
    mlfp_pkg::result_t result_reg;

    // room for a new result when empty or when the held one leaves now
    assign space = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid        = valid_reg;
    assign m_status       = result_reg.status;
    assign m_packet_type  = result_reg.packet_type;
    assign m_payload_size = result_reg.payload_size;

endmodule

`default_nettype wire

// ===== design/magic_length_frame_parser.sv =====
`default_nettype none

// Byte-serial parser for length-prefixed frames.
// Input channel (s_valid/s_ready/s_data_byte): one stream byte per transfer.
// Output channel (m_valid/m_ready/m_*): one result per input byte, in order,
// carrying the byte status (invalid, valid, end of header, end of packet)
// and the packet type and payload size as assembled after that byte.
// A frame is a four-byte magic, a 16-bit little-endian type, a 32-bit
// little-endian payload size and the payload. A bad magic byte or a size
// above the limit sends the parser back to hunting for the magic.
// Configuration: cfg_wr_en/cfg_wr_data write the payload size limit
// (65536 after reset); write it only while no transfer is in flight.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one byte per cycle unless stalled; the parser state is updated
// in the same cycle the byte is taken; the output register holds the result.
// Stall: while a result waits with m_ready low, s_ready drops; s_ready is
// high when the output register is empty or being emptied.
// Reset (aresetn low, synchronous): parser hunts for the first magic byte,
// type and size read zero, output register is empty.
module magic_length_frame_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [15:0]      m_packet_type,
    output logic [31:0]      m_payload_size,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data
);

    logic              max_size_reg;
    logic [31:0]       max_payload_size_reg;
    logic              accept;
    logic              space;
    mlfp_pkg::result_t result;

    // input transfer
    assign s_ready = space;
    assign accept  = s_valid && space;

    // payload size limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_size_reg <= mlfp_pkg::MaxPayloadReset;
        end else if (cfg_wr_en) begin
            max_payload_size_reg <= cfg_wr_data;
        end
    end

    // tracks whether the limit was ever written, for the checks below
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            max_size_reg <= 1'b1;
        end
    end

    mlfp_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .data_byte        (s_data_byte),
        .max_payload_size (max_payload_size_reg),
        .result           (result)
    );

    mlfp_out_stage u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (accept),
        .result         (result),
        .space          (space),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_packet_type  (m_packet_type),
        .m_payload_size (m_payload_size)
    );

`ifndef SYNTHESIS
    // every input transfer leaves a result in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("input transfer left no result");

    // a stalled result blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

    // an end of header never carries an empty payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == mlfp_pkg::ST_END_HEADER) |-> (m_payload_size != 32'd0))
        else $error("end of header with zero payload size");

    // with the default limit an accepted header stays within it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !max_size_reg && (m_status == mlfp_pkg::ST_END_HEADER)
        |-> (m_payload_size <= mlfp_pkg::MaxPayloadReset))
        else $error("accepted header above the size limit");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } rx_style_t;

    localparam logic [3:0][7:0] MagicSeq = {mlfp_pkg::Magic3, mlfp_pkg::Magic2,
                                            mlfp_pkg::Magic1, mlfp_pkg::Magic0};
    localparam int unsigned RandomBytes = 600;
    localparam int unsigned LongHold = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_packet_type;
    logic [31:0] m_payload_size;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    // parser state as the testbench sees it
    logic [3:0]  pm_phase = mlfp_pkg::PH_MAGIC0;
    logic [15:0] pm_type = '0;
    logic [31:0] pm_size = '0;
    logic [32:0] pm_seen = '0;
    logic [31:0] pm_limit = mlfp_pkg::MaxPayloadReset;

    mlfp_pkg::result_t pending_results[$];
    int unsigned fault_count = 0;
    int unsigned bytes_sent = 0;

    // idling controls
    bit          tx_gaps = 1'b0;
    int unsigned burst_left = 0;
    rx_style_t   rx_style = RX_ALWAYS;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned rx_tick = 0;

    magic_length_frame_parser DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_packet_type  (m_packet_type),
        .m_payload_size (m_payload_size),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // back to hunting for the first magic byte
    function automatic void restart_hunt();
        pm_phase = mlfp_pkg::PH_MAGIC0;
        pm_seen = '0;
    endfunction

    // advance the parser by one byte and return the result it reports
    function automatic mlfp_pkg::result_t parse_byte(input logic [7:0] b);
        mlfp_pkg::result_t r;
        logic [3:0]  p;
        logic [32:0] total;
        p = (pm_phase > mlfp_pkg::PH_PAYLOAD) ? mlfp_pkg::PH_MAGIC0 : pm_phase;
        pm_seen = pm_seen + 33'd1;
        r.status = mlfp_pkg::ST_INVALID;
        if (p <= mlfp_pkg::PH_MAGIC3) begin
            if (b == MagicSeq[p[1:0]]) begin
                pm_phase = p + 4'd1;
                r.status = mlfp_pkg::ST_VALID;
            end else begin
                restart_hunt();
            end
        end else if (p <= mlfp_pkg::PH_TYPE1) begin
            if (p == mlfp_pkg::PH_TYPE0) pm_type[7:0] = b;
            else pm_type[15:8] = b;
            pm_phase = p + 4'd1;
            r.status = mlfp_pkg::ST_VALID;
        end else if (p <= mlfp_pkg::PH_SIZE3) begin
            pm_size[8 * (int'(p) - int'(mlfp_pkg::PH_SIZE0)) +: 8] = b;
            if (p != mlfp_pkg::PH_SIZE3) begin
                pm_phase = p + 4'd1;
                r.status = mlfp_pkg::ST_VALID;
            end else if (pm_size > pm_limit) begin
                restart_hunt();
            end else if (pm_size == '0) begin
                restart_hunt();
                r.status = mlfp_pkg::ST_END_PACKET;
            end else begin
                pm_phase = mlfp_pkg::PH_PAYLOAD;
                r.status = mlfp_pkg::ST_END_HEADER;
            end
        end else begin
            total = {1'b0, pm_size} + 33'(mlfp_pkg::HeaderLen);
            if (total > pm_seen) begin
                r.status = mlfp_pkg::ST_VALID;
            end else begin
                restart_hunt();
                r.status = mlfp_pkg::ST_END_PACKET;
            end
        end
        r.packet_type = pm_type;
        r.payload_size = pm_size;
        return r;
    endfunction

    // receiver: long hold-offs on request, otherwise the current stall style
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ((rx_tick % 7) < 4);
            endcase
        end
        rx_tick++;
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        mlfp_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: status %0d", m_status);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fault_count++;
                end
                if (m_packet_type !== want.packet_type) begin
                    $error("packet_type: expected %0h, got %0h",
                           want.packet_type, m_packet_type);
                    fault_count++;
                end
                if (m_payload_size !== want.payload_size) begin
                    $error("payload_size: expected %0h, got %0h",
                           want.payload_size, m_payload_size);
                    fault_count++;
                end
            end
        end
    end

    // offer one byte, with random gaps between bursts, and wait for its transfer
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left != 0) burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(parse_byte(b));
        bytes_sent++;
    endtask

    // stop sending until every expected result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [31:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pm_limit = value;
    endtask

    // header bytes up to cut; a short header ends in one random byte
    task automatic send_header(input logic [15:0] ptype, input logic [31:0] psize,
                               input int unsigned cut);
        logic [79:0] hdr;
        hdr = {psize, ptype, MagicSeq};
        for (int i = 0; i < cut; i++) send_byte(hdr[8 * i +: 8]);
        if (cut < mlfp_pkg::HeaderLen) send_byte(8'($urandom));
    endtask

    task automatic send_frame(input logic [15:0] ptype, input logic [31:0] psize);
        send_header(ptype, psize, mlfp_pkg::HeaderLen);
        if (psize != 0 && psize <= pm_limit)
            repeat (psize) send_byte(8'($urandom));
    endtask

    // wrong magic bytes, extremes, and a mismatch that is not rechecked
    task automatic test_hunting();
        tx_gaps = 1'b1;
        rx_style = RX_RANDOM;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(mlfp_pkg::Magic0);
        send_byte(8'h00);
        send_byte(mlfp_pkg::Magic0);
        send_byte(mlfp_pkg::Magic0);
        send_byte(mlfp_pkg::Magic1);
        send_byte(mlfp_pkg::Magic0);
        send_byte(mlfp_pkg::Magic1);
        send_byte(mlfp_pkg::Magic2);
        send_byte(8'hFF);
    endtask

    // zero-size frame, one-byte frame, oversized header at the reset limit
    task automatic test_frames();
        send_frame(16'hFFFF, 32'd0);
        send_frame(16'h0000, 32'd1);
        send_frame(16'h1234, 32'hFFFF_FFFF);
        send_byte(8'h00);
    endtask

    // sizes on both sides of small limits
    task automatic test_limits();
        set_limit(32'd0);
        send_frame(16'hA55A, 32'd0);
        send_frame(16'h5AA5, 32'd1);
        set_limit(32'd3);
        send_frame(16'h0F0F, 32'd3);
        send_frame(16'hF0F0, 32'd4);
    endtask

    // mostly well-formed frames, with broken headers and noise mixed in
    task automatic test_random_stream();
        int unsigned stop_at;
        int unsigned frames_left;
        logic [15:0] ptype;
        logic [31:0] psize;
        stop_at = bytes_sent + RandomBytes;
        frames_left = 0;
        while (bytes_sent < stop_at) begin
            if (frames_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       set_limit(32'd0);
                    1:       set_limit(32'($urandom_range(1, 16)));
                    2:       set_limit(32'd20);
                    default: set_limit(mlfp_pkg::MaxPayloadReset);
                endcase
                tx_gaps = 1'($urandom_range(0, 1));
                rx_style = rx_style_t'($urandom_range(0, 2));
                frames_left = $urandom_range(4, 16);
            end
            frames_left--;
            ptype = 16'($urandom);
            case ($urandom_range(0, 9))
                0, 1:    psize = (pm_limit <= 32'd32) ? pm_limit : 32'($urandom_range(0, 12));
                2:       psize = pm_limit + 32'd1 + 32'($urandom_range(0, 300));
                3:       psize = $urandom | 32'h8000_0000;
                default: psize = 32'($urandom_range(0, 12));
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2:  repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
                3, 4, 5:  send_header(ptype, psize,
                                      $urandom_range(1, mlfp_pkg::HeaderLen - 1));
                default:  send_frame(ptype, psize);
            endcase
        end
    endtask

    // long receiver hold-off while bytes flow, a full pause, then RX_PATTERN
    task automatic test_backpressure();
        set_limit(mlfp_pkg::MaxPayloadReset);
        tx_gaps = 1'b0;
        rx_style = RX_ALWAYS;
        hold_req = LongHold;
        send_frame(16'($urandom), 32'd16);
        drain();
        rx_style = RX_PATTERN;
        send_frame(16'($urandom), 32'd5);
    endtask

    // largest size under the largest limit: the payload never ends
    task automatic test_endless_payload();
        set_limit(32'hFFFF_FFFF);
        tx_gaps = 1'b1;
        rx_style = RX_RANDOM;
        send_header(16'($urandom), 32'hFFFF_FFFF, mlfp_pkg::HeaderLen);
        repeat (20) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hunting();
        test_frames();
        test_limits();
        test_random_stream();
        test_backpressure();
        test_endless_payload();
        drain();
        repeat (4) @(posedge aclk);
        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
